// ===== design/utf_pkg.sv =====
`default_nettype none

package utf_pkg;

    localparam int unsigned SECS_W = 64;
    localparam int unsigned TIME_W = 16;
    localparam int unsigned DATE_W = 16;

    // 1980-01-01 and 2108-01-01 in seconds since 1970
    localparam logic [63:0] UNIX_1980 = 64'd315532800;
    localparam logic [63:0] UNIX_2108 = 64'd4354819200;
    localparam logic [31:0] UNIX_1980_LO = 32'd315532800;

    // day = (r >> 7) / 675, by reciprocal with 2^35 scale
    localparam logic [25:0] DAY_RECIP = 26'd50903317;
    localparam logic [9:0]  DAY_DIV = 10'd675;
    // year estimate = day / 365, 2^24 scale
    localparam logic [15:0] YEAR_RECIP = 16'd45965;
    // hour = sod / 3600, 2^27 scale
    localparam logic [15:0] HOUR_RECIP = 16'd37283;
    localparam logic [11:0] HOUR_SECONDS = 12'd3600;
    // minute = rs / 60, 2^18 scale
    localparam logic [12:0] MIN_RECIP = 13'd4370;
    localparam logic [5:0]  MINUTE_SECONDS = 6'd60;

    localparam logic [7:0]  NONLEAP_YEAR = 8'd120;
    localparam logic [8:0]  FEB29_DOY = 9'd59;

    localparam logic [TIME_W-1:0] TIME_MAX = 16'((23 << 11) | (59 << 5) | 29);
    localparam logic [DATE_W-1:0] DATE_MAX = 16'((127 << 9) | (12 << 5) | 31);
    localparam logic [DATE_W-1:0] DATE_MIN = 16'((0 << 9) | (1 << 5) | 1);
    localparam logic [TIME_W-1:0] TIME_MIN = 16'd0;

    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] v;
        case (m)
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    function automatic logic is_leap(input logic [7:0] y);
        return (y[1:0] == 2'b00) && (y != NONLEAP_YEAR);
    endfunction

    // first day of year y, counted from 1980-01-01
    function automatic logic [15:0] year_base(input logic [7:0] y);
        logic [16:0] days;
        logic [8:0]  y3;
        logic [6:0]  leaps;
        days  = 17'(y) * 17'd365;
        y3    = 9'(y) + 9'd3;
        leaps = y3[8:2] - ((y > NONLEAP_YEAR) ? 7'd1 : 7'd0);
        return 16'(days + 17'(leaps));
    endfunction

endpackage

`default_nettype wire

// ===== design/unix_to_fat_time_core.sv =====
`default_nettype none
// channel   direction  handshake            payload
// command   in         start (busy low)     unix_seconds
// result    out        done, one cycle      fat_time, fat_date
//
// One transfer is taken every cycle; busy stays low.
// Seven pipeline stages: stages A to F and the output stage, each registered.
// The chain of reciprocal multiplies (day, year, hour, minute) sets the depth.
// Reset clears only the valid bits; data registers carry no reset.
// The receiver cannot stall, so the pipeline never holds.

module unix_to_fat_time_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [utf_pkg::SECS_W-1:0] unix_seconds,
    output logic                              done,
    output logic [utf_pkg::TIME_W-1:0]        fat_time,
    output logic [utf_pkg::DATE_W-1:0]        fat_date
);
    import utf_pkg::*;

    localparam int unsigned LATENCY = 7;

    typedef enum logic [1:0] {
        CLAMP_NONE,
        CLAMP_LOW,
        CLAMP_HIGH
    } clamp_t;

    logic [LATENCY-1:0] valid_reg, valid_next;

    // stage A
    logic [31:0] a_r_reg, a_r_next;
    clamp_t      a_clamp_reg, a_clamp_next;
    // stage B
    logic [50:0] b_prod_reg, b_prod_next;
    logic [24:0] b_q1_reg;
    logic [6:0]  b_lo_reg;
    clamp_t      b_clamp_reg;
    // stage C
    logic [15:0] c_day_reg, c_day_next;
    logic [16:0] c_sod_reg, c_sod_next;
    logic [31:0] c_yprod_reg, c_yprod_next;
    clamp_t      c_clamp_reg;
    // stage D
    logic [7:0]  d_year_reg;
    logic [32:0] d_hprod_reg, d_hprod_next;
    logic [15:0] d_day_reg;
    logic [16:0] d_sod_reg;
    clamp_t      d_clamp_reg;
    // stage E
    logic [4:0]  e_hour_reg, e_hour_next;
    logic [11:0] e_rs_reg, e_rs_next;
    logic [15:0] e_base_reg, e_base_next;
    logic [15:0] e_base_m1_reg, e_base_m1_next;
    logic [7:0]  e_year_reg;
    logic [15:0] e_day_reg;
    clamp_t      e_clamp_reg;
    // stage F
    logic [6:0]  f_year_reg, f_year_next;
    logic [8:0]  f_doy_reg, f_doy_next;
    logic [24:0] f_mprod_reg, f_mprod_next;
    logic [4:0]  f_hour_reg;
    logic [11:0] f_rs_reg;
    clamp_t      f_clamp_reg;
    // output stage
    logic [TIME_W-1:0] out_time_reg, out_time_next;
    logic [DATE_W-1:0] out_date_reg, out_date_next;

    logic [25:0] c_mul675;
    logic [24:0] c_rem;
    logic [16:0] e_mul3600;
    logic [7:0]  e_year_m1;
    logic        f_take_prev;
    logic [15:0] f_doy_wide;
    logic [5:0]  g_min;
    logic [11:0] g_mul60;
    logic [11:0] g_sec;
    logic        g_leap;
    logic        g_feb29;
    logic [8:0]  g_dd;
    logic [3:0]  g_month;
    logic [8:0]  g_day;
    logic [6:0]  g_year;

    assign busy = 1'b0;

    always_comb
    begin
        valid_next = {valid_reg[LATENCY-2:0], start & ~busy};

        // stage A: range check and offset to 1980
        if (unix_seconds[SECS_W-1] || (unsigned'(unix_seconds) < UNIX_1980))
            a_clamp_next = CLAMP_LOW;
        else if (unsigned'(unix_seconds) >= UNIX_2108)
            a_clamp_next = CLAMP_HIGH;
        else
            a_clamp_next = CLAMP_NONE;
        a_r_next = unix_seconds[31:0] - UNIX_1980_LO;

        // stage B: reciprocal of 675 on r / 128
        b_prod_next = 51'(a_r_reg[31:7]) * 51'(DAY_RECIP);

        // stage C: day count, second of day, year estimate product
        c_day_next   = b_prod_reg[50:35];
        c_mul675     = 26'(c_day_next) * 26'(DAY_DIV);
        c_rem        = b_q1_reg - c_mul675[24:0];
        c_sod_next   = {c_rem[9:0], b_lo_reg};
        c_yprod_next = 32'(c_day_next) * 32'(YEAR_RECIP);

        // stage D: hour product
        d_hprod_next = 33'(c_sod_reg) * 33'(HOUR_RECIP);

        // stage E: hour, rest of hour, both year bases
        e_hour_next    = d_hprod_reg[31:27];
        e_mul3600      = 17'(e_hour_next) * 17'(HOUR_SECONDS);
        e_rs_next      = 12'(d_sod_reg - e_mul3600);
        e_year_m1      = d_year_reg - 8'd1;
        e_base_next    = year_base(d_year_reg);
        e_base_m1_next = year_base(e_year_m1);

        // stage F: step the year back when the estimate overshoots
        f_take_prev = e_base_reg > e_day_reg;
        if (f_take_prev)
        begin
            f_year_next = 7'(e_year_reg - 8'd1);
            f_doy_wide  = e_day_reg - e_base_m1_reg;
        end
        else
        begin
            f_year_next = e_year_reg[6:0];
            f_doy_wide  = e_day_reg - e_base_reg;
        end
        f_doy_next   = f_doy_wide[8:0];
        f_mprod_next = 25'(e_rs_reg) * 25'(MIN_RECIP);

        // output stage: minute, seconds, month and day, clamp
        g_min   = f_mprod_reg[23:18];
        g_mul60 = 12'(g_min) * 12'(MINUTE_SECONDS);
        g_sec   = f_rs_reg - g_mul60;

        g_year  = f_year_reg;
        g_leap  = is_leap({1'b0, f_year_reg});
        g_feb29 = g_leap && (f_doy_reg == FEB29_DOY);
        if (g_leap && (f_doy_reg > FEB29_DOY))
            g_dd = f_doy_reg - 9'd1;
        else
            g_dd = f_doy_reg;

        g_month = 4'd1;
        for (int k = 2; k <= 12; k++)
        begin
            if (month_start(4'(k)) <= g_dd)
                g_month = g_month + 4'd1;
        end
        // leap day reads as day 29 of February
        if (g_feb29)
            g_month = 4'd2;
        g_day = g_dd - month_start(g_month) + 9'd1;

        case (f_clamp_reg)
            CLAMP_LOW:
            begin
                out_time_next = TIME_MIN;
                out_date_next = DATE_MIN;
            end
            CLAMP_HIGH:
            begin
                out_time_next = TIME_MAX;
                out_date_next = DATE_MAX;
            end
            default:
            begin
                out_time_next = {f_hour_reg, g_min, g_sec[5:1]};
                out_date_next = {g_year, g_month, g_day[4:0]};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        a_r_reg       <= a_r_next;
        a_clamp_reg   <= a_clamp_next;

        b_prod_reg    <= b_prod_next;
        b_q1_reg      <= a_r_reg[31:7];
        b_lo_reg      <= a_r_reg[6:0];
        b_clamp_reg   <= a_clamp_reg;

        c_day_reg     <= c_day_next;
        c_sod_reg     <= c_sod_next;
        c_yprod_reg   <= c_yprod_next;
        c_clamp_reg   <= b_clamp_reg;

        d_year_reg    <= c_yprod_reg[31:24];
        d_hprod_reg   <= d_hprod_next;
        d_day_reg     <= c_day_reg;
        d_sod_reg     <= c_sod_reg;
        d_clamp_reg   <= c_clamp_reg;

        e_hour_reg    <= e_hour_next;
        e_rs_reg      <= e_rs_next;
        e_base_reg    <= e_base_next;
        e_base_m1_reg <= e_base_m1_next;
        e_year_reg    <= d_year_reg;
        e_day_reg     <= d_day_reg;
        e_clamp_reg   <= d_clamp_reg;

        f_year_reg    <= f_year_next;
        f_doy_reg     <= f_doy_next;
        f_mprod_reg   <= f_mprod_next;
        f_hour_reg    <= e_hour_reg;
        f_rs_reg      <= e_rs_reg;
        f_clamp_reg   <= e_clamp_reg;

        out_time_reg  <= out_time_next;
        out_date_reg  <= out_date_next;
    end

    assign done     = valid_reg[LATENCY-1];
    assign fat_time = out_time_reg;
    assign fat_date = out_date_reg;

    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##7 done)
        else $error("accepted command did not produce a result after 7 cycles");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (fat_date[8:5] != 4'd0) && (fat_date[8:5] <= 4'd12))
        else $error("month field out of range");

    a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (fat_date[4:0] != 5'd0))
        else $error("day field is zero");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (fat_time[15:11] <= 5'd23) && (fat_time[10:5] <= 6'd59)
                 && (fat_time[4:0] <= 5'd29))
        else $error("time field out of range");

endmodule

`default_nettype wire

// ===== tb/sv/fat_stamp_checker.sv =====
module fat_stamp_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic                       busy,
    input  wire logic [utf_pkg::SECS_W-1:0] unix_seconds,
    input  wire logic                       done,
    input  wire logic [utf_pkg::TIME_W-1:0] fat_time,
    input  wire logic [utf_pkg::DATE_W-1:0] fat_date,
    output int                              mismatches,
    output int                              outstanding,
    output int                              compared
);

    typedef struct packed {
        logic [utf_pkg::SECS_W-1:0] secs;
        logic [utf_pkg::TIME_W-1:0] hms;
        logic [utf_pkg::DATE_W-1:0] ymd;
    } fat_stamp_t;

    localparam logic [63:0]  DAY_SECONDS       = 64'd86400;
    localparam int unsigned  DAYS_BEFORE_1980  = 365 * 10 + 2;
    localparam int unsigned  SKIPPED_LEAP_YEAR = 120;
    localparam int unsigned  FEB29_OFFSET      = 59;

    int unsigned month_first_day [1:12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                            304, 334};

    fat_stamp_t stamp_q[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
        compared    = 0;
    end

    function automatic int unsigned leap_days_before(input int unsigned yr);
        int unsigned n;
        n = (yr + 3) / 4;
        // 2100 is not a leap year
        if (yr > SKIPPED_LEAP_YEAR)
            n--;
        return n;
    endfunction

    function automatic fat_stamp_t predict_stamp(input logic [63:0] secs);
        fat_stamp_t  r;
        int unsigned day;
        int unsigned yr;
        int unsigned base;
        int unsigned mon;
        int unsigned dom;
        int unsigned hh;
        int unsigned mm;
        int unsigned ss;
        bit          leap;
        r.secs = secs;
        if (secs[63] || secs < utf_pkg::UNIX_1980) begin
            r.hms = utf_pkg::TIME_MIN;
            r.ymd = utf_pkg::DATE_MIN;
        end
        else if (secs >= utf_pkg::UNIX_2108) begin
            r.hms = utf_pkg::TIME_MAX;
            r.ymd = utf_pkg::DATE_MAX;
        end
        else begin
            day  = 32'(secs / DAY_SECONDS) - DAYS_BEFORE_1980;
            yr   = day / 365;
            base = yr * 365 + leap_days_before(yr);
            if (base > day) begin
                yr--;
                base = yr * 365 + leap_days_before(yr);
            end
            day  = day - base;
            leap = (yr % 4 == 0) && (yr != SKIPPED_LEAP_YEAR);
            if (leap && day == FEB29_OFFSET) begin
                mon = 2;
                dom = 29;
            end
            else begin
                // fold the leap day away, then use the common-year table
                if (leap && day > FEB29_OFFSET)
                    day--;
                mon = 12;
                while (month_first_day[mon] > day)
                    mon--;
                dom = day - month_first_day[mon] + 1;
            end
            hh = 32'((secs / 64'd3600) % 64'd24);
            mm = 32'((secs / 64'd60) % 64'd60);
            ss = 32'(secs % 64'd60) >> 1;
            r.hms = {hh[4:0], mm[5:0], ss[4:0]};
            r.ymd = {yr[6:0], mon[3:0], dom[4:0]};
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] secs,
                                   input logic [15:0] got, input logic [15:0] want);
        mismatches++;
        $display("%0t: %s, unix_seconds %0d: got %h, want %h",
                 $time, what, $signed(secs), got, want);
    endtask

    always @(posedge clk) begin
        fat_stamp_t want;
        if (rst_n) begin
            if (start && !busy)
                stamp_q.push_back(predict_stamp(unix_seconds));
            if (done) begin
                if (stamp_q.size() == 0) begin
                    report_mismatch("result with no transfer pending", '0, fat_date, '0);
                end
                else begin
                    want = stamp_q.pop_front();
                    compared++;
                    if (fat_time !== want.hms)
                        report_mismatch("fat_time mismatch", want.secs, fat_time, want.hms);
                    if (fat_date !== want.ymd)
                        report_mismatch("fat_date mismatch", want.secs, fat_date, want.ymd);
                end
            end
            // publish after the edge so the sender reads a settled count
            outstanding <= stamp_q.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;

    localparam int RANDOM_ITEMS = 650;
    localparam int GAP_MAX      = 14;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [utf_pkg::SECS_W-1:0] unix_seconds;
    logic                       done;
    logic [utf_pkg::TIME_W-1:0] fat_time;
    logic [utf_pkg::DATE_W-1:0] fat_date;

    int mismatches;
    int outstanding;
    int compared;
    int sent;

    logic [63:0] corners [0:22];

    unix_to_fat_time_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .unix_seconds (unix_seconds),
        .done         (done),
        .fat_time     (fat_time),
        .fat_date     (fat_date)
    );

    fat_stamp_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .unix_seconds (unix_seconds),
        .done         (done),
        .fat_time     (fat_time),
        .fat_date     (fat_date),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .compared     (compared)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #200000;
        $display("FAILURE");
        $finish;
    end

    // hold the command until taken, then idle for gap cycles
    task automatic send_stamp(input logic [63:0] secs, input int gap);
        unix_seconds <= secs;
        start        <= 1'b1;
        do @(posedge clk); while (busy);
        sent++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    function automatic logic [63:0] draw_unix_seconds();
        int unsigned kind;
        logic [63:0] span;
        kind = $urandom_range(0, 99);
        span = utf_pkg::UNIX_2108 - utf_pkg::UNIX_1980;
        if (kind < 60)
            return utf_pkg::UNIX_1980 + ({$urandom, $urandom} % span);
        // land on the first or last seconds of a random day
        if (kind < 70)
            return utf_pkg::UNIX_1980 + 64'($urandom_range(0, 46750)) * 64'd86400
                   + 64'(($urandom_range(0, 1) ? 86396 : 0) + $urandom_range(0, 3));
        if (kind < 75)
            return utf_pkg::UNIX_1980 - 64'd2000 + 64'($urandom_range(0, 4000));
        if (kind < 80)
            return utf_pkg::UNIX_2108 - 64'd2000 + 64'($urandom_range(0, 4000));
        if (kind < 90)
            return {$urandom, $urandom};
        if (kind < 95)
            return -64'($urandom_range(1, 100000));
        return {32'd0, $urandom};
    endfunction

    initial begin
        bit burst;
        rst_n        = 1'b0;
        start        = 1'b0;
        unix_seconds = '0;
        sent         = 0;
        burst        = 1'b0;
        corners = '{
            64'h8000_0000_0000_0000,   // most negative
            64'hFFFF_FFFF_FFFF_FFFF,   // -1
            64'd0,
            64'd315532799,             // last second before 1980
            64'd315532800,
            64'd315532801,             // odd second drops
            64'd315619199,             // 1980-01-01 23:59:59
            64'd320630399,             // 1980-02-28 23:59:59
            64'd320630400,             // 1980-02-29
            64'd320716800,             // 1980-03-01
            64'd347155199,             // end of leap year 1980
            64'd951782400,             // 2000-02-29
            64'd2147483647,
            64'd2147483648,
            64'd4107456000,            // 2100-02-28
            64'd4107542400,            // 2100-03-01, no leap day
            64'd4133894400,            // 2100-12-31
            64'd4233686400,            // 2104-02-29
            64'd4294967295,
            64'd4294967296,
            64'd4354819199,            // largest stamp reached exactly
            64'd4354819200,            // first clamped value
            64'h7FFF_FFFF_FFFF_FFFF
        };
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corners[i])
            send_stamp(corners[i], $urandom_range(0, GAP_MAX));
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // some blocks run back to back with no idle cycles
            if (i % 40 == 0)
                burst = ($urandom_range(0, 2) == 0);
            if (i == RANDOM_ITEMS / 2)
                drain_results();
            send_stamp(draw_unix_seconds(), burst ? 0 : $urandom_range(0, GAP_MAX));
        end
        drain_results();
        repeat (12) @(posedge clk);

        $display("converted %0d timestamps: clamp edges, leap days, 2100, and random values",
                 sent);
        $display("across the signed range, %0d results compared, %0d mismatches",
                 compared, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
